[hdl/gmhr_pkg.sv]
// gmhr_pkg: shared types and constants for the gated mono haptic ring
// request and result payloads, queue command format, op and csr codes
// no dependencies
package gmhr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int BLEN_W      = 14;
   localparam int GATE_W      = 17;
   localparam int COUNT_W     = 32;
   localparam int CSR_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_PULL = 2'd1;
   localparam logic [1:0] OP_GATE = 2'd2;

   localparam logic CSR_DECAY  = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   localparam logic [CSR_W-1:0]  DECAY_RESET  = 16'd65520;
   localparam logic [CSR_W-1:0]  THRESH_RESET = 16'd131;
   localparam logic [GATE_W-1:0] GATE_ONE     = 17'h10000;

   typedef struct packed {
      logic [1:0]                 op;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       frame_end;
      logic                       block_first;
      logic                       block_last;
      logic [BLEN_W-1:0]          block_len;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       block_end;
      logic                       block_active;
   } rsp_type;

   typedef struct packed {
      logic [CSR_W-1:0] decay_factor;
      logic [CSR_W-1:0] active_threshold;
   } cfg_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_PULL,
      CMD_GATE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SAMPLE_W-1:0] data;
      logic                first;
      logic                last;
      logic [BLEN_W-1:0]   blen;
   } cmd_type;

endpackage

[hdl/gmhr_div.sv]
// gmhr_div: iterative signed-by-unsigned divider, one quotient bit per cycle
// quotient truncates toward zero; low 16 bits of the quotient are returned
// depends on gmhr_pkg
module gmhr_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]                    den,
   output logic                                busy,
   output logic                                done,
   output logic [gmhr_pkg::SAMPLE_W-1:0]       quot
);

   localparam int STEP_W = $clog2(NUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic              neg_ff;
   logic [STEP_W-1:0] step_ff;
   logic [NUM_W-1:0]  dvd_ff;
   logic [DEN_W:0]    rem_ff;
   logic [DEN_W-1:0]  den_ff;

   logic [NUM_W-1:0]  num_mag;
   logic [DEN_W:0]    trial;
   logic              fits;
   logic [NUM_W-1:0]  quot_full;

   assign num_mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign trial     = {rem_ff[DEN_W-1:0], dvd_ff[NUM_W-1]};
   assign fits      = trial >= {1'b0, den_ff};
   assign quot_full = neg_ff ? (~dvd_ff + NUM_W'(1)) : dvd_ff;

   assign busy = busy_ff || done_ff;
   assign done = done_ff;
   assign quot = quot_full[gmhr_pkg::SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(NUM_W - 1);
            neg_ff  <= num[NUM_W-1];
            dvd_ff  <= num_mag;
            rem_ff  <= '0;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= fits ? (trial - {1'b0, den_ff}) : trial;
            dvd_ff <= {dvd_ff[NUM_W-2:0], fits};
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - STEP_W'(1);
            end
         end
      end
   end

endmodule

[hdl/gmhr_front.sv]
// gmhr_front: accepts request items, sums channel samples per frame and
// averages them through the divider, forwards pulls and gate opens as commands
// depends on gmhr_pkg and gmhr_div
module gmhr_front #(
   parameter int MAX_CHANNELS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  gmhr_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output gmhr_pkg::cmd_type q_data
);

   localparam int CNT_W = $clog2(MAX_CHANNELS + 2);
   localparam int SUM_W = gmhr_pkg::SAMPLE_W + 1 + $clog2(MAX_CHANNELS);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CHANNELS);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_CHANNELS + 1);

   logic signed [SUM_W-1:0]      sum_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         pend_ff;
   logic [gmhr_pkg::SAMPLE_W-1:0] pend_data_ff;

   logic                         accept;
   logic                         is_push;
   logic                         is_fwd;
   logic                         cnt_room;
   logic signed [SUM_W-1:0]      sum_in;
   logic [CNT_W-1:0]             cnt_in;
   logic                         div_start;
   logic                         div_busy;
   logic                         div_done;
   logic [gmhr_pkg::SAMPLE_W-1:0] div_quot;

   assign full    = div_busy || pend_ff || q_full;
   assign accept  = push && !full;
   assign is_push = req_data.op == gmhr_pkg::OP_PUSH;
   assign is_fwd  = (req_data.op == gmhr_pkg::OP_PULL) || (req_data.op == gmhr_pkg::OP_GATE);

   // samples beyond the channel limit are not summed, the frame is marked over
   assign cnt_room = cnt_ff < CNT_MAX;
   assign sum_in   = cnt_room ? (sum_ff + SUM_W'(req_data.sample_in)) : sum_ff;
   assign cnt_in   = cnt_room ? (cnt_ff + CNT_W'(1)) : CNT_OVER;

   assign div_start = accept && is_push && req_data.frame_end && (cnt_in <= CNT_MAX);

   gmhr_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_in),
      .den   (cnt_in),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      q_push       = (pend_ff && !q_full) || (accept && is_fwd);
      q_data.data  = pend_data_ff;
      q_data.first = req_data.block_first;
      q_data.last  = req_data.block_last;
      q_data.blen  = req_data.block_len;
      if (pend_ff) begin
         q_data.kind = gmhr_pkg::CMD_WRITE;
      end else if (req_data.op == gmhr_pkg::OP_PULL) begin
         q_data.kind = gmhr_pkg::CMD_PULL;
      end else begin
         q_data.kind = gmhr_pkg::CMD_GATE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (accept && is_push) begin
            if (req_data.frame_end) begin
               sum_ff <= '0;
               cnt_ff <= '0;
            end else begin
               sum_ff <= sum_in;
               cnt_ff <= cnt_in;
            end
         end
         // average waits here until the queue has room
         if (div_done) begin
            pend_ff      <= 1'b1;
            pend_data_ff <= div_quot;
         end else if (pend_ff && !q_full) begin
            pend_ff <= 1'b0;
         end
      end
   end

endmodule

[hdl/gmhr_queue.sv]
// gmhr_queue: short command queue between front and back
// depends on gmhr_pkg
module gmhr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  gmhr_pkg::cmd_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output gmhr_pkg::cmd_type rd_data,
   output logic              empty
);

   localparam int QD = gmhr_pkg::QUEUE_DEPTH;
   localparam int QW = gmhr_pkg::QPTR_W;

   gmhr_pkg::cmd_type slot_ff [QD];
   logic [QW-1:0]     wr_ptr_ff;
   logic [QW-1:0]     rd_ptr_ff;
   logic [QW:0]       count_ff;

   logic do_wr;
   logic do_rd;

   assign full    = count_ff == (QW + 1)'(QD);
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + QW'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + QW'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + (QW + 1)'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - (QW + 1)'(1);
         end
      end
   end

endmodule

[hdl/gmhr_back.sv]
// gmhr_back: executes queued commands: ring writes, gate opens and gated pulls
// holds the sample ring, read/write counts, gate level, block peak and result register
// depends on gmhr_pkg
module gmhr_back #(
   parameter int RING_DEPTH = 16384
) (
   input  logic              clock,
   input  logic              reset,
   input  gmhr_pkg::cfg_type cfg,
   input  gmhr_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output gmhr_pkg::rsp_type rsp_data
);

   localparam int RIDX_W = $clog2(RING_DEPTH);
   localparam int CW     = gmhr_pkg::COUNT_W;
   localparam int SW     = gmhr_pkg::SAMPLE_W;
   localparam int GW     = gmhr_pkg::GATE_W;
   localparam logic [CW-1:0] HALF_DEPTH = CW'(RING_DEPTH / 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIN
   } state_type;

   logic [SW-1:0]  ring_mem [RING_DEPTH];
   logic [SW-1:0]  rdata_ff;

   state_type          state_ff;
   logic [CW-1:0]      wc_ff;
   logic [CW-1:0]      rc_ff;
   logic [GW-1:0]      gate_ff;
   logic [GW-1:0]      peak_ff;
   logic               got_ff;
   logic               have_ff;
   logic               last_ff;
   logic signed [33:0] prod_ff;
   logic [32:0]        gprod_ff;
   logic               rsp_valid_ff;
   gmhr_pkg::rsp_type  rsp_ff;

   logic               is_write;
   logic               is_pull;
   logic [CW-1:0]      blen_w;
   logic [CW-1:0]      avail;
   logic               jump;
   logic [CW-1:0]      rc_eff;
   logic               have;
   logic signed [SW-1:0] v;
   logic signed [17:0] gate_s;
   logic signed [33:0] prod_adj;
   logic signed [17:0] res;
   logic [17:0]        mag;
   logic [GW-1:0]      peak_in;
   logic               active;

   assign is_write = cmd.kind == gmhr_pkg::CMD_WRITE;
   assign is_pull  = cmd.kind == gmhr_pkg::CMD_PULL;
   assign cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty && (!is_pull || !rsp_valid_ff);

   // lag check: a reader too far behind jumps to block_len behind the writer
   assign blen_w = CW'(cmd.blen);
   assign avail  = wc_ff - rc_ff;
   assign jump   = cmd.first && (avail > (blen_w + HALF_DEPTH));
   assign rc_eff = jump ? (wc_ff - blen_w) : rc_ff;
   assign have   = rc_eff != wc_ff;

   assign v      = have_ff ? $signed(rdata_ff) : '0;
   assign gate_s = $signed({1'b0, gate_ff});

   // divide by 65536 truncating toward zero
   assign prod_adj = prod_ff + (prod_ff[33] ? 34'sd65535 : 34'sd0);
   assign res      = prod_adj[33:16];
   assign mag      = res[17] ? 18'(-res) : 18'(res);
   assign peak_in  = (mag[GW-1:0] > peak_ff) ? mag[GW-1:0] : peak_ff;
   assign active   = got_ff && (peak_in >= GW'(cfg.active_threshold));

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd_pop && is_write) begin
         ring_mem[wc_ff[RIDX_W-1:0]] <= cmd.data;
      end
      if (cmd_pop && is_pull) begin
         rdata_ff <= ring_mem[rc_eff[RIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wc_ff        <= '0;
         rc_ff        <= '0;
         gate_ff      <= '0;
         peak_ff      <= '0;
         got_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_pop) begin
                  unique case (cmd.kind)
                     gmhr_pkg::CMD_WRITE: begin
                        wc_ff <= wc_ff + CW'(1);
                     end
                     gmhr_pkg::CMD_GATE: begin
                        gate_ff <= gmhr_pkg::GATE_ONE;
                     end
                     gmhr_pkg::CMD_PULL: begin
                        rc_ff   <= have ? (rc_eff + CW'(1)) : rc_eff;
                        have_ff <= have;
                        last_ff <= cmd.last;
                        if (cmd.first) begin
                           peak_ff <= '0;
                           got_ff  <= have;
                        end else begin
                           got_ff  <= got_ff || have;
                        end
                        state_ff <= ST_MUL;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_MUL: begin
               prod_ff  <= v * gate_s;
               gprod_ff <= gate_ff * cfg.decay_factor;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               gate_ff             <= gprod_ff[32:16];
               rsp_ff.sample_out   <= res[SW-1:0];
               rsp_ff.block_end    <= last_ff;
               rsp_ff.block_active <= last_ff && active;
               rsp_valid_ff        <= 1'b1;
               if (last_ff) begin
                  peak_ff <= '0;
                  got_ff  <= 1'b0;
               end else begin
                  peak_ff <= peak_in;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[hdl/gated_mono_haptic_ring.sv]
// gated_mono_haptic_ring: top level, front, command queue, back and csr registers
// a pull passes the queue and the back end's multiply and finish states; pulls do not overlap
// gate and ring-write commands complete in the back end's idle state
// a frame end within the channel limit runs the averaging divider, full held high meanwhile
// reset is synchronous: clears counts, gate, peak and queue, csrs go to defaults; ring undefined
// depends on gmhr_pkg, gmhr_front, gmhr_queue, gmhr_back
module gated_mono_haptic_ring #(
   parameter int RING_DEPTH   = 16384,
   parameter int MAX_CHANNELS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  gmhr_pkg::req_type              req_data,
   output logic                           empty,
   input  logic                           pop,
   output gmhr_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [gmhr_pkg::CSR_W-1:0]     csr_wdata
);

   gmhr_pkg::cfg_type cfg_ff;
   gmhr_pkg::cmd_type q_wr_data;
   gmhr_pkg::cmd_type q_rd_data;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_factor     <= gmhr_pkg::DECAY_RESET;
         cfg_ff.active_threshold <= gmhr_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gmhr_pkg::CSR_DECAY:  cfg_ff.decay_factor     <= csr_wdata;
            gmhr_pkg::CSR_THRESH: cfg_ff.active_threshold <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   gmhr_front #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   gmhr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   gmhr_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (q_rd_data),
      .cmd_empty (q_empty),
      .cmd_pop   (q_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
